### src/fpa_pkg.sv
// shared types and constants for the fixed-point alu
// no dependencies
`default_nettype none
package fpa_pkg;

    localparam int FPA_FRAC_BITS   = 8;
    localparam int FPA_QUEUE_DEPTH = 4;
    localparam int FPA_DATA_W      = 32;

    typedef enum logic [3:0] {
        OP_ADD      = 4'd0,
        OP_SUB      = 4'd1,
        OP_MUL      = 4'd2,
        OP_DIV      = 4'd3,
        OP_GT       = 4'd4,
        OP_LT       = 4'd5,
        OP_GE       = 4'd6,
        OP_LE       = 4'd7,
        OP_EQ       = 4'd8,
        OP_NE       = 4'd9,
        OP_MIN      = 4'd10,
        OP_MAX      = 4'd11,
        OP_INC      = 4'd12,
        OP_DEC      = 4'd13,
        OP_FROM_INT = 4'd14,
        OP_TO_INT   = 4'd15
    } fpa_op_t;

    // one classified transaction as it travels from front to back
    typedef struct packed {
        fpa_op_t                       op;
        logic signed [FPA_DATA_W-1:0]  a;
        logic signed [FPA_DATA_W-1:0]  b;
        logic                          div_zero;
        logic                          div_run;
    } fpa_item_t;

endpackage
`default_nettype wire

### src/fpa_front.sv
// front end: accepts input transactions and classifies them for the back end
// depends on fpa_pkg
`default_nettype none
module fpa_front (
    input  wire logic                      in_valid,
    output logic                           in_ready,
    input  wire logic [3:0]                opcode,
    input  wire logic signed [31:0]        operand_a,
    input  wire logic signed [31:0]        operand_b,
    input  wire logic                      q_full,
    output logic                           q_push,
    output fpa_pkg::fpa_item_t             q_item
);
    import fpa_pkg::*;

    logic b_zero;

    assign b_zero   = (operand_b == '0);
    assign in_ready = !q_full;
    assign q_push   = in_valid && !q_full;

    always_comb
    begin
        q_item.op       = fpa_op_t'(opcode);
        q_item.a        = operand_a;
        q_item.b        = operand_b;
        // divide by zero resolves without the iterative divider
        q_item.div_zero = (fpa_op_t'(opcode) == OP_DIV) && b_zero;
        q_item.div_run  = (fpa_op_t'(opcode) == OP_DIV) && !b_zero;
    end

endmodule
`default_nettype wire

### src/fpa_queue.sv
// small fifo between front and back end
// depends on fpa_pkg
`default_nettype none
module fpa_queue #(
    parameter int DEPTH = fpa_pkg::FPA_QUEUE_DEPTH
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 push,
    input  wire fpa_pkg::fpa_item_t   push_item,
    output logic                      full,
    input  wire logic                 pop,
    output logic                      head_valid,
    output fpa_pkg::fpa_item_t        head_item
);
    import fpa_pkg::*;

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    fpa_item_t        mem_reg [DEPTH];
    logic [PW-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]    count_reg, count_next;

    assign full       = (count_reg == CW'(DEPTH));
    assign head_valid = (count_reg != '0);
    assign head_item  = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule
`default_nettype wire

### src/fpa_back.sv
// back end: execute stage with multiplier and radix-2 divider, output register
// depends on fpa_pkg
`default_nettype none
module fpa_back #(
    parameter int FRAC_BITS = fpa_pkg::FPA_FRAC_BITS
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 head_valid,
    input  wire fpa_pkg::fpa_item_t   head_item,
    output logic                      head_pop,
    output logic                      out_valid,
    input  wire logic                 out_ready,
    output logic signed [31:0]        result_raw,
    output logic                      compare_true,
    output logic                      divide_by_zero
);
    import fpa_pkg::*;

    localparam int NW = 32 + FRAC_BITS;
    localparam int CW = $clog2(NW + 1);

    logic                 e_valid_reg, e_valid_next;
    fpa_item_t            e_item_reg;
    logic signed [63:0]   e_prod_reg;
    logic [CW-1:0]        div_cnt_reg, div_cnt_next;
    logic [32:0]          div_rem_reg, div_rem_next;
    logic [NW-1:0]        div_q_reg, div_q_next;
    logic [31:0]          div_d_reg;
    logic                 div_neg_reg;

    logic                 o_valid_reg, o_valid_next;
    logic signed [31:0]   o_res_reg, o_res_next;
    logic                 o_cmp_reg, o_cmp_next;
    logic                 o_dz_reg, o_dz_next;

    logic                 out_free, e_done, e_fire;
    logic [31:0]          mag_a, mag_b;
    logic [32:0]          rem_sh;
    logic                 rem_ge;
    logic signed [63:0]   prod_shift;
    logic [31:0]          quot;

    assign out_free = !o_valid_reg || out_ready;
    assign e_done   = e_valid_reg && (div_cnt_reg == '0);
    assign e_fire   = e_done && out_free;
    assign head_pop = head_valid && (!e_valid_reg || e_fire);

    assign mag_a = head_item.a[31] ? 32'(-head_item.a) : 32'(head_item.a);
    assign mag_b = head_item.b[31] ? 32'(-head_item.b) : 32'(head_item.b);

    // one quotient bit per cycle
    assign rem_sh = {div_rem_reg[31:0], div_q_reg[NW-1]};
    assign rem_ge = rem_sh >= {1'b0, div_d_reg};

    assign prod_shift = e_prod_reg >>> FRAC_BITS;
    assign quot       = div_neg_reg ? 32'(-div_q_reg[31:0]) : div_q_reg[31:0];

    always_comb
    begin
        e_valid_next = e_valid_reg;
        div_cnt_next = div_cnt_reg;
        div_rem_next = div_rem_reg;
        div_q_next   = div_q_reg;
        if (div_cnt_reg != '0)
        begin
            div_cnt_next = div_cnt_reg - 1'b1;
            div_rem_next = rem_ge ? rem_sh - {1'b0, div_d_reg} : rem_sh;
            div_q_next   = {div_q_reg[NW-2:0], rem_ge};
        end
        if (e_fire)
        begin
            e_valid_next = 1'b0;
        end
        if (head_pop)
        begin
            e_valid_next = 1'b1;
            div_cnt_next = head_item.div_run ? CW'(NW) : '0;
            div_rem_next = '0;
            div_q_next   = {mag_a, {FRAC_BITS{1'b0}}};
        end
    end

    always_comb
    begin
        o_valid_next = o_valid_reg;
        o_res_next   = o_res_reg;
        o_cmp_next   = o_cmp_reg;
        o_dz_next    = o_dz_reg;
        if (out_valid && out_ready)
        begin
            o_valid_next = 1'b0;
        end
        if (e_fire)
        begin
            o_valid_next = 1'b1;
            o_res_next   = '0;
            o_cmp_next   = 1'b0;
            o_dz_next    = 1'b0;
            unique case (e_item_reg.op)
                OP_ADD:      o_res_next = e_item_reg.a + e_item_reg.b;
                OP_SUB:      o_res_next = e_item_reg.a - e_item_reg.b;
                OP_MUL:      o_res_next = prod_shift[31:0];
                OP_DIV:
                begin
                    o_res_next = e_item_reg.div_zero ? 32'hFFFF_FFFF : quot;
                    o_dz_next  = e_item_reg.div_zero;
                end
                OP_GT:       o_cmp_next = e_item_reg.a >  e_item_reg.b;
                OP_LT:       o_cmp_next = e_item_reg.a <  e_item_reg.b;
                OP_GE:       o_cmp_next = e_item_reg.a >= e_item_reg.b;
                OP_LE:       o_cmp_next = e_item_reg.a <= e_item_reg.b;
                OP_EQ:       o_cmp_next = e_item_reg.a == e_item_reg.b;
                OP_NE:       o_cmp_next = e_item_reg.a != e_item_reg.b;
                OP_MIN:      o_res_next = (e_item_reg.a < e_item_reg.b) ? e_item_reg.a
                                                                        : e_item_reg.b;
                OP_MAX:      o_res_next = (e_item_reg.a > e_item_reg.b) ? e_item_reg.a
                                                                        : e_item_reg.b;
                OP_INC:      o_res_next = e_item_reg.a + 32'sd1;
                OP_DEC:      o_res_next = e_item_reg.a - 32'sd1;
                OP_FROM_INT: o_res_next = e_item_reg.a <<< FRAC_BITS;
                OP_TO_INT:   o_res_next = e_item_reg.a >>> FRAC_BITS;
                default:     o_res_next = '0;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            e_valid_reg <= 1'b0;
            div_cnt_reg <= '0;
            o_valid_reg <= 1'b0;
        end
        else
        begin
            e_valid_reg <= e_valid_next;
            div_cnt_reg <= div_cnt_next;
            o_valid_reg <= o_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        div_rem_reg <= div_rem_next;
        div_q_reg   <= div_q_next;
        o_res_reg   <= o_res_next;
        o_cmp_reg   <= o_cmp_next;
        o_dz_reg    <= o_dz_next;
        if (head_pop)
        begin
            e_item_reg  <= head_item;
            e_prod_reg  <= head_item.a * head_item.b;
            div_d_reg   <= mag_b;
            div_neg_reg <= head_item.a[31] ^ head_item.b[31];
        end
    end

    assign out_valid      = o_valid_reg;
    assign result_raw     = o_res_reg;
    assign compare_true   = o_cmp_reg;
    assign divide_by_zero = o_dz_reg;

endmodule
`default_nettype wire

### src/fixed_point_alu_core.sv
// top level of the q-format fixed-point alu
// depends on fpa_pkg, fpa_front, fpa_queue, fpa_back
`default_nettype none
// usage
//   input channel: in_valid / in_ready with opcode, operand_a, operand_b
//   output channel: out_valid / out_ready with result_raw, compare_true,
//   divide_by_zero; exactly one output transaction per input transaction,
//   in the order accepted
//   path: each accepted transaction passes the queue, the execute stage and
//   the output register; a divide with a nonzero divisor also runs the divider
//   throughput: one transaction per cycle unless the receiver stalls; a
//   running divide holds the execute stage until the one-bit-per-cycle
//   divider is done, while the queue keeps taking up to QUEUE_DEPTH transactions
//   reset: rst_n clears queue, execute stage and output register; nothing
//   is pending afterwards
//   receiver stall: the output register holds its transaction, the execute
//   stage then holds, and in_ready drops once the queue fills
module fixed_point_alu_core #(
    parameter int FRAC_BITS   = fpa_pkg::FPA_FRAC_BITS,
    parameter int QUEUE_DEPTH = fpa_pkg::FPA_QUEUE_DEPTH
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                in_valid,
    output logic                     in_ready,
    input  wire logic [3:0]          opcode,
    input  wire logic signed [31:0]  operand_a,
    input  wire logic signed [31:0]  operand_b,
    output logic                     out_valid,
    input  wire logic                out_ready,
    output logic signed [31:0]       result_raw,
    output logic                     compare_true,
    output logic                     divide_by_zero
);
    import fpa_pkg::*;

    // front to queue
    logic        q_full;
    logic        q_push;
    fpa_item_t   q_item;

    // queue to back
    logic        head_valid;
    logic        head_pop;
    fpa_item_t   head_item;

    // front: accept and classify each transaction
    fpa_front u_front (
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .opcode    (opcode),
        .operand_a (operand_a),
        .operand_b (operand_b),
        .q_full    (q_full),
        .q_push    (q_push),
        .q_item    (q_item)
    );

    // decoupling queue so a long divide does not block acceptance
    fpa_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (q_push),
        .push_item  (q_item),
        .full       (q_full),
        .pop        (head_pop),
        .head_valid (head_valid),
        .head_item  (head_item)
    );

    // back: execute and hold the result until taken
    fpa_back #(
        .FRAC_BITS (FRAC_BITS)
    ) u_back (
        .clk            (clk),
        .rst_n          (rst_n),
        .head_valid     (head_valid),
        .head_item      (head_item),
        .head_pop       (head_pop),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .result_raw     (result_raw),
        .compare_true   (compare_true),
        .divide_by_zero (divide_by_zero)
    );

endmodule
`default_nettype wire
